// ===== rtl/core/md5sh_pkg.sv =====
package md5sh_pkg;

  localparam int WORD_W   = 32;
  localparam int BUF_DEPTH = 16;
  localparam int ADDR_W   = $clog2(BUF_DEPTH);
  localparam int LEN_W    = 64;
  localparam int ROUNDS   = 64;
  localparam int ROUND_W  = $clog2(ROUNDS);
  localparam int DIGEST_WORDS = 4;
  localparam int DIGEST_IDX_W = $clog2(DIGEST_WORDS);

  localparam logic [WORD_W-1:0] IV0 = 32'h67452301;
  localparam logic [WORD_W-1:0] IV1 = 32'hefcdab89;
  localparam logic [WORD_W-1:0] IV2 = 32'h98badcfe;
  localparam logic [WORD_W-1:0] IV3 = 32'h10325476;

  localparam logic [7:0]        PAD_BYTE = 8'h80;
  localparam logic [ADDR_W-1:0] LEN_SLOT = ADDR_W'(BUF_DEPTH - 2);
  localparam logic [ADDR_W-1:0] LAST_SLOT = ADDR_W'(BUF_DEPTH - 1);
  localparam logic [2:0]        FULL_BYTES = 3'd4;

  typedef enum logic [2:0] {
    TOP_IDLE,
    TOP_PAD,
    TOP_LEN_HI,
    TOP_WAIT,
    TOP_OUT
  } top_state_t;

  typedef enum logic [1:0] {
    CORE_IDLE,
    CORE_RUN,
    CORE_ADD
  } core_state_t;

  typedef struct packed {
    logic start;
    logic init;
  } core_req_t;

  function automatic logic [WORD_W-1:0] round_k(input logic [ROUND_W-1:0] r);
    logic [WORD_W-1:0] k;
    case (r)
      6'd0:  k = 32'hd76aa478; 6'd1:  k = 32'he8c7b756;
      6'd2:  k = 32'h242070db; 6'd3:  k = 32'hc1bdceee;
      6'd4:  k = 32'hf57c0faf; 6'd5:  k = 32'h4787c62a;
      6'd6:  k = 32'ha8304613; 6'd7:  k = 32'hfd469501;
      6'd8:  k = 32'h698098d8; 6'd9:  k = 32'h8b44f7af;
      6'd10: k = 32'hffff5bb1; 6'd11: k = 32'h895cd7be;
      6'd12: k = 32'h6b901122; 6'd13: k = 32'hfd987193;
      6'd14: k = 32'ha679438e; 6'd15: k = 32'h49b40821;
      6'd16: k = 32'hf61e2562; 6'd17: k = 32'hc040b340;
      6'd18: k = 32'h265e5a51; 6'd19: k = 32'he9b6c7aa;
      6'd20: k = 32'hd62f105d; 6'd21: k = 32'h02441453;
      6'd22: k = 32'hd8a1e681; 6'd23: k = 32'he7d3fbc8;
      6'd24: k = 32'h21e1cde6; 6'd25: k = 32'hc33707d6;
      6'd26: k = 32'hf4d50d87; 6'd27: k = 32'h455a14ed;
      6'd28: k = 32'ha9e3e905; 6'd29: k = 32'hfcefa3f8;
      6'd30: k = 32'h676f02d9; 6'd31: k = 32'h8d2a4c8a;
      6'd32: k = 32'hfffa3942; 6'd33: k = 32'h8771f681;
      6'd34: k = 32'h6d9d6122; 6'd35: k = 32'hfde5380c;
      6'd36: k = 32'ha4beea44; 6'd37: k = 32'h4bdecfa9;
      6'd38: k = 32'hf6bb4b60; 6'd39: k = 32'hbebfbc70;
      6'd40: k = 32'h289b7ec6; 6'd41: k = 32'heaa127fa;
      6'd42: k = 32'hd4ef3085; 6'd43: k = 32'h04881d05;
      6'd44: k = 32'hd9d4d039; 6'd45: k = 32'he6db99e5;
      6'd46: k = 32'h1fa27cf8; 6'd47: k = 32'hc4ac5665;
      6'd48: k = 32'hf4292244; 6'd49: k = 32'h432aff97;
      6'd50: k = 32'hab9423a7; 6'd51: k = 32'hfc93a039;
      6'd52: k = 32'h655b59c3; 6'd53: k = 32'h8f0ccc92;
      6'd54: k = 32'hffeff47d; 6'd55: k = 32'h85845dd1;
      6'd56: k = 32'h6fa87e4f; 6'd57: k = 32'hfe2ce6e0;
      6'd58: k = 32'ha3014314; 6'd59: k = 32'h4e0811a1;
      6'd60: k = 32'hf7537e82; 6'd61: k = 32'hbd3af235;
      6'd62: k = 32'h2ad7d2bb; 6'd63: k = 32'heb86d391;
      default: k = '0;
    endcase
    return k;
  endfunction

  function automatic logic [4:0] rot_amt(input logic [3:0] idx);
    logic [4:0] s;
    case (idx)
      4'd0:  s = 5'd7;  4'd1:  s = 5'd12; 4'd2:  s = 5'd17; 4'd3:  s = 5'd22;
      4'd4:  s = 5'd5;  4'd5:  s = 5'd9;  4'd6:  s = 5'd14; 4'd7:  s = 5'd20;
      4'd8:  s = 5'd4;  4'd9:  s = 5'd11; 4'd10: s = 5'd16; 4'd11: s = 5'd23;
      4'd12: s = 5'd6;  4'd13: s = 5'd10; 4'd14: s = 5'd15; 4'd15: s = 5'd21;
      default: s = '0;
    endcase
    return s;
  endfunction

  function automatic logic [ADDR_W-1:0] msg_index(input logic [ROUND_W-1:0] r);
    logic [ADDR_W-1:0] lo;
    logic [ADDR_W-1:0] g;
    lo = r[ADDR_W-1:0];
    case (r[ROUND_W-1:ROUND_W-2])
      2'd0: g = lo;
      2'd1: g = lo * ADDR_W'(5) + ADDR_W'(1);
      2'd2: g = lo * ADDR_W'(3) + ADDR_W'(5);
      2'd3: g = lo * ADDR_W'(7);
      default: g = '0;
    endcase
    return g;
  endfunction

  function automatic logic [WORD_W-1:0] round_mix(input logic [1:0] grp,
                                                  input logic [WORD_W-1:0] b,
                                                  input logic [WORD_W-1:0] c,
                                                  input logic [WORD_W-1:0] d);
    logic [WORD_W-1:0] f;
    case (grp)
      2'd0: f = (b & c) | (~b & d);
      2'd1: f = (b & d) | (c & ~d);
      2'd2: f = b ^ c ^ d;
      2'd3: f = c ^ (b | ~d);
      default: f = '0;
    endcase
    return f;
  endfunction

  function automatic logic [WORD_W-1:0] rotl(input logic [WORD_W-1:0] x,
                                             input logic [4:0] s);
    logic [2*WORD_W-1:0] dbl;
    dbl = {x, x} << s;
    return dbl[2*WORD_W-1:WORD_W];
  endfunction

endpackage

// ===== rtl/core/md5sh_if.sv =====
interface md5sh_in_if;
  logic        valid;
  logic        ready;
  logic [31:0] data;
  logic [2:0]  byte_count;
  logic        last;

  modport source (output valid, data, byte_count, last, input ready);
  modport sink   (input valid, data, byte_count, last, output ready);
endinterface

interface md5sh_out_if;
  logic        valid;
  logic        ready;
  logic [31:0] digest_word;
  logic        final_word;

  modport source (output valid, digest_word, final_word, input ready);
  modport sink   (input valid, digest_word, final_word, output ready);
endinterface

// ===== rtl/core/md5_stream_hasher.sv =====
// Streaming MD5: one message word is accepted per cycle, but every 16th word
// stalls input while the shared round unit runs the 64 rounds of the block and
// then adds the result into the chaining values. After the last word, padding
// words are written one per cycle except while a block compresses, and one or
// two final blocks are compressed before the four digest words appear.
// Synchronous reset restores the initial chaining values, zero length and slot.
module md5_stream_hasher
  import md5sh_pkg::*;
(
  input  logic              clk,
  input  logic              rst,
  md5sh_in_if.sink          msg,
  md5sh_out_if.source       digest
);

  top_state_t              state;
  top_state_t              state_next;
  top_state_t              ret;
  top_state_t              ret_next;
  logic [ADDR_W-1:0]       fill;
  logic [ADDR_W-1:0]       fill_next;
  logic [LEN_W-1:0]        bit_len;
  logic [LEN_W-1:0]        bit_len_next;
  logic                    need_pad;
  logic                    need_pad_next;
  logic [DIGEST_IDX_W-1:0] out_idx;
  logic [DIGEST_IDX_W-1:0] out_idx_next;

  logic                    wr_en;
  logic [WORD_W-1:0]       wr_data;
  top_state_t              after_wr;
  logic [2:0]              nbytes;
  logic [ADDR_W-1:0]       rd_addr;
  logic [WORD_W-1:0]       rd_data;
  logic [WORD_W-1:0]       chain [DIGEST_WORDS];
  core_req_t               core_req;
  logic                    core_done;

  md5sh_msg_ram u_ram (
    .clk     (clk),
    .wr_en   (wr_en),
    .wr_addr (fill),
    .wr_data (wr_data),
    .rd_addr (rd_addr),
    .rd_data (rd_data)
  );

  md5sh_core u_core (
    .clk     (clk),
    .rst     (rst),
    .req     (core_req),
    .done    (core_done),
    .rd_addr (rd_addr),
    .rd_data (rd_data),
    .chain   (chain)
  );

  assign nbytes = (msg.byte_count > FULL_BYTES) ? FULL_BYTES : msg.byte_count;

  assign digest.valid       = (state == TOP_OUT);
  assign digest.digest_word = chain[out_idx];
  assign digest.final_word  = (out_idx == DIGEST_IDX_W'(DIGEST_WORDS - 1));

  always_comb begin
    state_next    = state;
    ret_next      = ret;
    fill_next     = fill;
    bit_len_next  = bit_len;
    need_pad_next = need_pad;
    out_idx_next  = out_idx;
    wr_en         = 1'b0;
    wr_data       = '0;
    after_wr      = state;
    core_req      = '0;
    msg.ready     = 1'b0;

    case (state)
      TOP_IDLE: begin
        msg.ready = 1'b1;
        if (msg.valid) begin
          wr_en = 1'b1;
          if (!msg.last) begin
            wr_data      = msg.data;
            bit_len_next = bit_len + LEN_W'(WORD_W);
            after_wr     = TOP_IDLE;
          end else begin
            bit_len_next = bit_len + LEN_W'({nbytes, 3'b000});
            after_wr     = TOP_PAD;
            case (nbytes)
              3'd0: wr_data = {24'h0, PAD_BYTE};
              3'd1: wr_data = {16'h0, PAD_BYTE, msg.data[7:0]};
              3'd2: wr_data = {8'h0, PAD_BYTE, msg.data[15:0]};
              3'd3: wr_data = {PAD_BYTE, msg.data[23:0]};
              default: begin
                wr_data       = msg.data;
                need_pad_next = 1'b1;
              end
            endcase
          end
        end
      end
      TOP_PAD: begin
        wr_en    = 1'b1;
        after_wr = TOP_PAD;
        if (need_pad) begin
          wr_data       = {24'h0, PAD_BYTE};
          need_pad_next = 1'b0;
        end else if (fill != LEN_SLOT) begin
          wr_data = '0;
        end else begin
          wr_data  = bit_len[WORD_W-1:0];
          after_wr = TOP_LEN_HI;
        end
      end
      TOP_LEN_HI: begin
        wr_en    = 1'b1;
        wr_data  = bit_len[LEN_W-1:WORD_W];
        after_wr = TOP_OUT;
      end
      TOP_WAIT: begin
        if (core_done) state_next = ret;
      end
      TOP_OUT: begin
        if (digest.ready) begin
          if (out_idx == DIGEST_IDX_W'(DIGEST_WORDS - 1)) begin
            core_req.init = 1'b1;
            out_idx_next  = '0;
            bit_len_next  = '0;
            fill_next     = '0;
            need_pad_next = 1'b0;
            state_next    = TOP_IDLE;
          end else begin
            out_idx_next = out_idx + DIGEST_IDX_W'(1);
          end
        end
      end
      default: state_next = TOP_IDLE;
    endcase

    if (wr_en) begin
      fill_next = fill + ADDR_W'(1);
      if (fill == LAST_SLOT) begin
        core_req.start = 1'b1;
        ret_next       = after_wr;
        state_next     = TOP_WAIT;
      end else begin
        state_next = after_wr;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state    <= TOP_IDLE;
      ret      <= TOP_IDLE;
      fill     <= '0;
      bit_len  <= '0;
      need_pad <= 1'b0;
      out_idx  <= '0;
    end else begin
      state    <= state_next;
      ret      <= ret_next;
      fill     <= fill_next;
      bit_len  <= bit_len_next;
      need_pad <= need_pad_next;
      out_idx  <= out_idx_next;
    end
  end

endmodule

// ===== rtl/core/md5sh_msg_ram.sv =====
module md5sh_msg_ram
  import md5sh_pkg::*;
(
  input  logic              clk,
  input  logic              wr_en,
  input  logic [ADDR_W-1:0] wr_addr,
  input  logic [WORD_W-1:0] wr_data,
  input  logic [ADDR_W-1:0] rd_addr,
  output logic [WORD_W-1:0] rd_data
);

  logic [WORD_W-1:0] mem [BUF_DEPTH];

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
  end

  always_ff @(posedge clk) begin
    rd_data <= mem[rd_addr];
  end

endmodule

// ===== rtl/core/md5sh_core.sv =====
module md5sh_core
  import md5sh_pkg::*;
(
  input  logic              clk,
  input  logic              rst,
  input  core_req_t         req,
  output logic              done,
  output logic [ADDR_W-1:0] rd_addr,
  input  logic [WORD_W-1:0] rd_data,
  output logic [WORD_W-1:0] chain [DIGEST_WORDS]
);

  core_state_t        state;
  core_state_t        state_next;
  logic [ROUND_W-1:0] rnd;
  logic [WORD_W-1:0]  a, b, c, d;
  logic [WORD_W-1:0]  mix;
  logic [WORD_W-1:0]  sum;
  logic [WORD_W-1:0]  b_next;

  always_comb begin
    mix    = round_mix(rnd[ROUND_W-1:ROUND_W-2], b, c, d);
    sum    = a + mix + round_k(rnd) + rd_data;
    b_next = b + rotl(sum, rot_amt({rnd[ROUND_W-1:ROUND_W-2], rnd[1:0]}));
  end

  always_comb begin
    state_next = state;
    done       = 1'b0;
    rd_addr    = msg_index(rnd + ROUND_W'(1));
    case (state)
      CORE_IDLE: begin
        rd_addr = msg_index('0);
        if (req.start) state_next = CORE_RUN;
      end
      CORE_RUN: begin
        if (rnd == ROUND_W'(ROUNDS - 1)) state_next = CORE_ADD;
      end
      CORE_ADD: begin
        done       = 1'b1;
        state_next = CORE_IDLE;
      end
      default: state_next = CORE_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= CORE_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_ff @(posedge clk) begin
    if (rst || req.init) begin
      chain[0] <= IV0;
      chain[1] <= IV1;
      chain[2] <= IV2;
      chain[3] <= IV3;
    end else if (state == CORE_ADD) begin
      chain[0] <= chain[0] + a;
      chain[1] <= chain[1] + b;
      chain[2] <= chain[2] + c;
      chain[3] <= chain[3] + d;
    end
  end

  always_ff @(posedge clk) begin
    case (state)
      CORE_IDLE: begin
        rnd <= '0;
        a   <= chain[0];
        b   <= chain[1];
        c   <= chain[2];
        d   <= chain[3];
      end
      CORE_RUN: begin
        rnd <= rnd + ROUND_W'(1);
        a   <= d;
        d   <= c;
        c   <= b;
        b   <= b_next;
      end
      default: begin
        rnd <= '0;
      end
    endcase
  end

endmodule

// ===== sim/testbench.sv =====
`timescale 1ns / 1ps

module testbench;

  typedef struct {
    logic [31:0] data;
    logic [2:0]  nbytes;
    logic        last;
    int unsigned gap;
    bit          drain;
  } msg_req_t;

  typedef struct {
    logic [31:0] word;
    logic        final_flag;
  } digest_word_t;

  localparam logic [31:0] SINE_ADD [64] = '{
    32'hd76aa478, 32'he8c7b756, 32'h242070db, 32'hc1bdceee,
    32'hf57c0faf, 32'h4787c62a, 32'ha8304613, 32'hfd469501,
    32'h698098d8, 32'h8b44f7af, 32'hffff5bb1, 32'h895cd7be,
    32'h6b901122, 32'hfd987193, 32'ha679438e, 32'h49b40821,
    32'hf61e2562, 32'hc040b340, 32'h265e5a51, 32'he9b6c7aa,
    32'hd62f105d, 32'h02441453, 32'hd8a1e681, 32'he7d3fbc8,
    32'h21e1cde6, 32'hc33707d6, 32'hf4d50d87, 32'h455a14ed,
    32'ha9e3e905, 32'hfcefa3f8, 32'h676f02d9, 32'h8d2a4c8a,
    32'hfffa3942, 32'h8771f681, 32'h6d9d6122, 32'hfde5380c,
    32'ha4beea44, 32'h4bdecfa9, 32'hf6bb4b60, 32'hbebfbc70,
    32'h289b7ec6, 32'heaa127fa, 32'hd4ef3085, 32'h04881d05,
    32'hd9d4d039, 32'he6db99e5, 32'h1fa27cf8, 32'hc4ac5665,
    32'hf4292244, 32'h432aff97, 32'hab9423a7, 32'hfc93a039,
    32'h655b59c3, 32'h8f0ccc92, 32'hffeff47d, 32'h85845dd1,
    32'h6fa87e4f, 32'hfe2ce6e0, 32'ha3014314, 32'h4e0811a1,
    32'hf7537e82, 32'hbd3af235, 32'h2ad7d2bb, 32'heb86d391
  };

  localparam int unsigned SHIFT_BY [16] = '{
    7, 12, 17, 22, 5, 9, 14, 20, 4, 11, 16, 23, 6, 10, 15, 21
  };

  localparam int unsigned HOLD_CYCLES = 1200;
  localparam int unsigned TAIL_CYCLES = 200;

  logic clk;
  logic rst = 1'b1;

  md5sh_in_if  msg ();
  md5sh_out_if digest ();

  md5_stream_hasher DUT (
    .clk    (clk),
    .rst    (rst),
    .msg    (msg),
    .digest (digest)
  );

  logic [31:0] md5_chain [4];
  logic [31:0] md5_block [16];
  logic [63:0] msg_bits;
  int unsigned block_fill;

  msg_req_t     msg_pending [$];
  digest_word_t digest_expect [$];

  int unsigned req_total;
  int unsigned req_sent;
  int unsigned msgs_sent;
  int unsigned digest_words_seen;
  int unsigned mismatches;
  int unsigned gap_left;
  int unsigned stall_left;
  int unsigned hold_left;
  bit          hold_done;
  bit          rx_eager;
  logic        req_taken;
  logic        word_taken;

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  function automatic void md5_restart();
    md5_chain[0] = 32'h67452301;
    md5_chain[1] = 32'hefcdab89;
    md5_chain[2] = 32'h98badcfe;
    md5_chain[3] = 32'h10325476;
    msg_bits = '0;
    block_fill = 0;
  endfunction

  function automatic logic [31:0] rol32(logic [31:0] x, int unsigned s);
    return (x << s) | (x >> (32 - s));
  endfunction

  function automatic void md5_compress();
    logic [31:0] a, b, c, d, f, t;
    int unsigned r, g;
    a = md5_chain[0];
    b = md5_chain[1];
    c = md5_chain[2];
    d = md5_chain[3];
    for (r = 0; r < 64; r++) begin
      case (r / 16)
        0: begin
          f = (b & c) | (~b & d);
          g = r % 16;
        end
        1: begin
          f = (b & d) | (c & ~d);
          g = (5 * r + 1) % 16;
        end
        2: begin
          f = b ^ c ^ d;
          g = (3 * r + 5) % 16;
        end
        default: begin
          f = c ^ (b | ~d);
          g = (7 * r) % 16;
        end
      endcase
      t = a + f + SINE_ADD[r] + md5_block[g];
      a = d;
      d = c;
      c = b;
      b = b + rol32(t, SHIFT_BY[(r / 16) * 4 + r % 4]);
    end
    md5_chain[0] += a;
    md5_chain[1] += b;
    md5_chain[2] += c;
    md5_chain[3] += d;
  endfunction

  function automatic void md5_absorb(logic [31:0] w);
    md5_block[block_fill] = w;
    block_fill++;
    if (block_fill == 16) begin
      md5_compress();
      block_fill = 0;
    end
  endfunction

  function automatic void predict_request(logic [31:0] data, logic [2:0] nbytes, logic last);
    int unsigned n;
    logic [31:0] mask;
    if (!last) begin
      msg_bits += 64'd32;
      md5_absorb(data);
      return;
    end
    n = (nbytes > 3'd4) ? 4 : nbytes;
    msg_bits += 64'(n * 8);
    if (n == 4) begin
      md5_absorb(data);
      md5_absorb(32'h80);
    end else begin
      mask = (32'h1 << (8 * n)) - 32'h1;
      md5_absorb((data & mask) | (32'h80 << (8 * n)));
    end
    if (block_fill == 15) md5_absorb('0);
    while (block_fill != 0 && block_fill < 14) md5_absorb('0);
    if (block_fill == 0) begin
      while (block_fill < 14) md5_absorb('0);
    end
    md5_absorb(msg_bits[31:0]);
    md5_absorb(msg_bits[63:32]);
    for (n = 0; n < 4; n++) digest_expect.push_back('{md5_chain[n], n == 3});
    md5_restart();
  endfunction

  function automatic void queue_req(logic [31:0] data, logic [2:0] nbytes, logic last,
                                    bit quiet, bit drain);
    msg_req_t r;
    r.data = data;
    r.nbytes = nbytes;
    r.last = last;
    r.gap = quiet ? 0 : $urandom_range(0, 7);
    r.drain = drain;
    msg_pending.push_back(r);
  endfunction

  function automatic void queue_message(int unsigned nwords, bit quiet, bit drain);
    int unsigned i;
    logic [31:0] w;
    for (i = 0; i < nwords; i++) begin
      case ($urandom_range(0, 9))
        0: w = '0;
        1: w = '1;
        default: w = $urandom;
      endcase
      queue_req(w, 3'($urandom_range(0, 7)), i == nwords - 1, quiet, drain && i == 0);
    end
  endfunction

  task automatic report_mismatch(string what, logic [31:0] got, logic [31:0] want);
    mismatches++;
    $display("%0t ns: %s mismatch: got %h, expected %h", $time, what, got, want);
  endtask

  always @(posedge clk) begin
    digest_word_t head;
    req_taken <= !rst && msg.valid && msg.ready;
    word_taken <= !rst && digest.valid && digest.ready;
    if (!rst) begin
      if (msg.valid && msg.ready) begin
        req_sent++;
        if (msg.last) msgs_sent++;
        predict_request(msg.data, msg.byte_count, msg.last);
      end
      if (digest.valid && digest.ready) begin
        digest_words_seen++;
        if (digest_expect.size() == 0) begin
          report_mismatch("unexpected digest word", digest.digest_word, '0);
        end else begin
          head = digest_expect.pop_front();
          if (digest.digest_word !== head.word)
            report_mismatch("digest_word", digest.digest_word, head.word);
          if (digest.final_word !== head.final_flag)
            report_mismatch("final_word", 32'(digest.final_word), 32'(head.final_flag));
        end
      end
    end
  end

  always @(negedge clk) begin
    msg_req_t head;
    if (rst) begin
      msg.valid <= 1'b0;
      gap_left <= 0;
    end else if (msg.valid && !req_taken) begin
      // hold the offered request
    end else if (gap_left != 0) begin
      msg.valid <= 1'b0;
      gap_left <= gap_left - 1;
    end else if (msg_pending.size() != 0 &&
                 !(msg_pending[0].drain && digest_expect.size() != 0)) begin
      head = msg_pending.pop_front();
      msg.valid <= 1'b1;
      msg.data <= head.data;
      msg.byte_count <= head.nbytes;
      msg.last <= head.last;
      gap_left <= head.gap;
    end else begin
      msg.valid <= 1'b0;
    end
  end

  always @(negedge clk) begin
    int unsigned nxt;
    if (rst) begin
      digest.ready <= 1'b0;
      stall_left <= 0;
      rx_eager <= 1'b0;
    end else if (hold_left != 0) begin
      digest.ready <= 1'b0;
    end else if (word_taken) begin
      if (digest.final_word) rx_eager <= ($urandom_range(0, 2) == 0);
      nxt = rx_eager ? 0 : $urandom_range(0, 7);
      stall_left <= nxt;
      digest.ready <= (nxt == 0);
    end else if (stall_left != 0) begin
      stall_left <= stall_left - 1;
      digest.ready <= (stall_left == 1);
    end else begin
      digest.ready <= 1'b1;
    end
  end

  // long output hold-off once the run is under way
  always @(negedge clk) begin
    if (rst) begin
      hold_left <= 0;
      hold_done <= 1'b0;
    end else if (hold_left != 0) begin
      hold_left <= hold_left - 1;
    end else if (!hold_done && digest_words_seen >= 48) begin
      hold_left <= HOLD_CYCLES;
      hold_done <= 1'b1;
    end
  end

  initial begin
    #2ms;
    $display("FAILED: results differ");
    $finish;
  end

  initial begin
    int unsigned i;
    bit mid_drain;
    msg.valid = 1'b0;
    msg.data = '0;
    msg.byte_count = '0;
    msg.last = 1'b0;
    digest.ready = 1'b0;
    req_sent = 0;
    msgs_sent = 0;
    digest_words_seen = 0;
    mismatches = 0;
    md5_restart();

    queue_req(32'hdeadbeef, 3'd0, 1'b1, 1'b0, 1'b0);
    queue_req(32'hffffffff, 3'd1, 1'b1, 1'b0, 1'b0);
    queue_req(32'h00000000, 3'd2, 1'b1, 1'b1, 1'b0);
    queue_req(32'hffffffff, 3'd3, 1'b1, 1'b0, 1'b0);
    queue_req(32'hffffffff, 3'd4, 1'b1, 1'b0, 1'b0);
    queue_req(32'h00000000, 3'd4, 1'b1, 1'b1, 1'b0);
    queue_req(32'h89abcdef, 3'd5, 1'b1, 1'b0, 1'b0);
    queue_req(32'h01234567, 3'd6, 1'b1, 1'b0, 1'b0);
    queue_req(32'h00000000, 3'd7, 1'b0, 1'b0, 1'b0);
    queue_req(32'hffffffff, 3'd7, 1'b1, 1'b0, 1'b0);
    // padding spills into a second block
    for (i = 0; i < 14; i++) queue_req($urandom, 3'($urandom_range(0, 7)), 1'b0, 1'b1, 1'b0);
    queue_req(32'h76543210, 3'd0, 1'b1, 1'b0, 1'b0);

    queue_message($urandom_range(1, 16), 1'b0, 1'b1);
    mid_drain = 1'b0;
    while (msg_pending.size() < 260) begin
      case ($urandom_range(0, 9))
        0: i = 1;
        1, 2: i = $urandom_range(17, 40);
        default: i = $urandom_range(1, 16);
      endcase
      queue_message(i, $urandom_range(0, 3) == 0, !mid_drain && msg_pending.size() >= 150);
      if (msg_pending.size() >= 150) mid_drain = 1'b1;
    end
    req_total = msg_pending.size();

    repeat (6) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    while (req_sent != req_total || digest_expect.size() != 0) @(posedge clk);
    repeat (TAIL_CYCLES) @(posedge clk);

    $display("Hashed %0d messages from %0d words, checked %0d digest words.",
             msgs_sent, req_sent, digest_words_seen);
    $display("Included empty and two-block padding, an output hold-off and input drains.");
    if (mismatches == 0 && digest_expect.size() == 0) begin
      $display("PASSED: all results match");
    end else begin
      $display("FAILED: results differ");
    end
    $finish;
  end

endmodule

// ===== md5_stream_hasher.f =====
rtl/core/md5sh_pkg.sv
rtl/core/md5sh_if.sv
rtl/core/md5sh_msg_ram.sv
rtl/core/md5sh_core.sv
rtl/core/md5_stream_hasher.sv
sim/testbench.sv
